### design/utf8vd_pkg.sv
// Package for the UTF-8 validating decoder.
// Holds the beat types, the result kinds and the decoding constants.
// Used by every module of the block; depends on nothing else.
package utf8vd_pkg;

    localparam int OFFSET_BITS_DEFAULT = 16;

    localparam logic [20:0] CP_MAX     = 21'h10FFFF;
    localparam logic [16:0] COUNT_MAX  = 17'h10000;
    localparam logic [20:0] FLOOR_TWO  = 21'h00007F;
    localparam logic [20:0] FLOOR_THREE = 21'h0007FF;
    localparam logic [20:0] FLOOR_FOUR = 21'h00FFFF;

    typedef enum logic [1:0] {
        KIND_CHAR      = 2'd0,
        KIND_MALFORMED = 2'd1,
        KIND_CLOSED    = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_string;
    } byte_beat_t;

    typedef struct packed {
        logic [20:0] code_point;
        kind_t       kind;
        logic [15:0] char_start;
        logic [16:0] char_count;
        logic        last;
    } result_beat_t;

endpackage

### design/utf8_validating_decoder.sv
// Top level of the UTF-8 validating decoder.
// Joins the decode core and the result register; depends on utf8vd_pkg,
// utf8vd_core and utf8vd_result_reg.
//
// The decoder gives at most one result beat per byte beat, in the cycle after
// the byte is taken, from a single result register. Every byte is checked and
// folded into the sequence state in the cycle it is accepted, so the sustained
// rate is one byte per clock while no held result beat stalls byte_ready.
// byte_ready follows result_ready combinationally: a byte is taken whenever the
// result register is empty or its beat leaves in the same cycle. Byte offsets
// saturate at 2^OFFSET_BITS-1 and are reported in their low 16 bits.
module utf8_validating_decoder #(
    parameter int OFFSET_BITS = utf8vd_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     byte_valid,
    output logic                     byte_ready,
    input  utf8vd_pkg::byte_beat_t   byte_beat,
    output logic                     result_valid,
    input  logic                     result_ready,
    output utf8vd_pkg::result_beat_t result
);

    logic                     accept;
    logic                     emit;
    logic                     space;
    utf8vd_pkg::result_beat_t core_result;

    assign byte_ready = space;
    assign accept     = byte_valid && space;

    utf8vd_core #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .beat   (byte_beat),
        .emit   (emit),
        .result (core_result)
    );

    utf8vd_result_reg u_result_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (accept && emit),
        .load_data    (core_result),
        .space        (space),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

### design/utf8vd_core.sv
// Decode core of the UTF-8 validating decoder: sequence state and checks.
// Updates its state on every accepted byte and flags the result it causes.
// Depends on utf8vd_pkg.
module utf8vd_core #(
    parameter int OFFSET_BITS = utf8vd_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  utf8vd_pkg::byte_beat_t   beat,
    output logic                     emit,
    output utf8vd_pkg::result_beat_t result
);

    logic [2:0]             cont_left_reg,  cont_left_next;
    logic [2:0]             seq_len_reg,    seq_len_next;
    logic [20:0]            acc_reg,        acc_next;
    logic [OFFSET_BITS-1:0] byte_pos_reg,   byte_pos_next;
    logic [OFFSET_BITS-1:0] seq_begin_reg,  seq_begin_next;
    logic [16:0]            valid_reg,      valid_next;
    logic                   failed_reg,     failed_next;

    logic [7:0]              b;
    logic                    eos;
    logic [2:0]              n_lead;
    logic                    run;
    logic [5:0]              lead_mask;
    logic [20:0]             acc_shift;
    logic [20:0]             floor_v;
    logic [2:0]              cont_dec;
    logic                    emit_char;
    logic                    emit_err;
    logic                    clear;
    logic [20:0]             cp;
    logic [16:0]             count_inc;
    logic [OFFSET_BITS-1:0]  start_sel;
    logic [OFFSET_BITS+15:0] start_wide;

    assign b   = beat.data_byte;
    assign eos = beat.end_of_string;

    // Number of ones that follow the top bit of a lead byte.
    always_comb
    begin
        n_lead = 3'd0;
        run    = 1'b1;
        for (int i = 6; i >= 0; i--)
        begin
            if (run && b[i])
            begin
                n_lead = n_lead + 3'd1;
            end
            else
            begin
                run = 1'b0;
            end
        end
    end

    assign lead_mask = 6'h3F >> n_lead;
    assign acc_shift = {acc_reg[14:0], b[5:0]};
    assign cont_dec  = cont_left_reg - 3'd1;
    assign count_inc = (valid_reg < utf8vd_pkg::COUNT_MAX) ? valid_reg + 17'd1 : valid_reg;

    always_comb
    begin
        unique case (seq_len_reg)
            3'd1:    floor_v = utf8vd_pkg::FLOOR_TWO;
            3'd2:    floor_v = utf8vd_pkg::FLOOR_THREE;
            default: floor_v = utf8vd_pkg::FLOOR_FOUR;
        endcase
    end

    always_comb
    begin
        cont_left_next = cont_left_reg;
        seq_len_next   = seq_len_reg;
        acc_next       = acc_reg;
        seq_begin_next = seq_begin_reg;
        valid_next     = valid_reg;
        failed_next    = failed_reg;
        byte_pos_next  = (byte_pos_reg != '1) ? byte_pos_reg + 1'b1 : byte_pos_reg;
        emit_char      = 1'b0;
        emit_err       = 1'b0;
        clear          = 1'b0;
        cp             = 21'd0;

        if (failed_reg)
        begin
            clear = eos;
        end
        else
        begin
            if (cont_left_reg == 3'd0)
            begin
                seq_begin_next = byte_pos_reg;
                if (!b[7])
                begin
                    emit_char = 1'b1;
                    cp        = {13'd0, b};
                end
                else if (!b[6])
                begin
                    emit_err = 1'b1;
                end
                else
                begin
                    seq_len_next   = n_lead;
                    cont_left_next = n_lead;
                    acc_next       = {15'd0, b[5:0] & lead_mask};
                    emit_err       = eos;
                end
            end
            else if (b[7:6] != 2'b10)
            begin
                emit_err = 1'b1;
            end
            else
            begin
                acc_next       = acc_shift;
                cont_left_next = cont_dec;
                if (cont_dec == 3'd0)
                begin
                    if (seq_len_reg > 3'd3 || acc_shift > utf8vd_pkg::CP_MAX
                        || acc_shift <= floor_v)
                    begin
                        emit_err = 1'b1;
                    end
                    else
                    begin
                        emit_char = 1'b1;
                        cp        = acc_shift;
                    end
                end
                else
                begin
                    emit_err = eos;
                end
            end

            if (emit_char)
            begin
                valid_next     = count_inc;
                cont_left_next = 3'd0;
            end
            if (emit_err)
            begin
                cont_left_next = 3'd0;
                failed_next    = 1'b1;
            end
            clear = eos && (emit_char || emit_err);
        end

        if (clear)
        begin
            cont_left_next = 3'd0;
            seq_len_next   = 3'd0;
            acc_next       = 21'd0;
            byte_pos_next  = '0;
            seq_begin_next = '0;
            valid_next     = 17'd0;
            failed_next    = 1'b0;
        end
    end

    // A byte in lead position starts its own sequence; every other result,
    // a kind-2 close included, reports the stored start of the sequence.
    assign start_sel  = (failed_reg || cont_left_reg != 3'd0) ? seq_begin_reg : byte_pos_reg;
    assign start_wide = {16'd0, start_sel};

    always_comb
    begin
        emit              = emit_char || emit_err || (failed_reg && eos);
        result.code_point = cp;
        result.char_start = start_wide[15:0];
        result.last       = eos;
        if (emit_char)
        begin
            result.kind       = utf8vd_pkg::KIND_CHAR;
            result.char_count = count_inc;
        end
        else if (emit_err)
        begin
            result.kind       = utf8vd_pkg::KIND_MALFORMED;
            result.char_count = valid_reg;
        end
        else
        begin
            result.kind       = utf8vd_pkg::KIND_CLOSED;
            result.char_count = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cont_left_reg <= 3'd0;
            seq_len_reg   <= 3'd0;
            acc_reg       <= 21'd0;
            byte_pos_reg  <= '0;
            seq_begin_reg <= '0;
            valid_reg     <= 17'd0;
            failed_reg    <= 1'b0;
        end
        else if (accept)
        begin
            cont_left_reg <= cont_left_next;
            seq_len_reg   <= seq_len_next;
            acc_reg       <= acc_next;
            byte_pos_reg  <= byte_pos_next;
            seq_begin_reg <= seq_begin_next;
            valid_reg     <= valid_next;
            failed_reg    <= failed_next;
        end
    end

endmodule

### design/utf8vd_result_reg.sv
// Result register of the UTF-8 validating decoder.
// Holds one result beat until it is taken and grants the byte channel.
// Depends on utf8vd_pkg.
module utf8vd_result_reg (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  utf8vd_pkg::result_beat_t load_data,
    output logic                     space,
    output logic                     result_valid,
    input  logic                     result_ready,
    output utf8vd_pkg::result_beat_t result
);

    logic                     valid_reg, valid_next;
    utf8vd_pkg::result_beat_t data_reg;

    // A new beat may enter in the same cycle the held one leaves.
    assign space = !valid_reg || result_ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule
